// ===== src/grw_pkg.sv =====
// ----------------------------------------------------------------------------
// grw_pkg
// shared types, widths and codes for the grid ray wall intersection core
// ----------------------------------------------------------------------------
package grw_pkg;

  // fixed field widths
  localparam int WIN_W  = 12;
  localparam int CRD_W  = 20;
  localparam int END_W  = 24;
  localparam int SIDE_W = 2;
  localparam int CFG_W  = 3;

  // defaults for top level parameters
  localparam int GRID_DEF = 64;
  localparam int FRAC_DEF = 8;

  localparam logic [WIN_W-1:0] WIN_RESET = WIN_W'(512);

  typedef enum logic [CFG_W-1:0] {
    CFG_WINDOW_SIZE = 3'd0,
    CFG_ORIGIN_X    = 3'd1,
    CFG_ORIGIN_Y    = 3'd2,
    CFG_PLAYER_X    = 3'd3,
    CFG_PLAYER_Y    = 3'd4
  } cfg_idx_t;

  typedef enum logic [SIDE_W-1:0] {
    SIDE_NONE = 2'd0,
    SIDE_VERT = 2'd1,
    SIDE_HORZ = 2'd2
  } side_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MAP_WB,
    ST_PASS,
    ST_START,
    ST_STEP,
    ST_LIMIT,
    ST_MUL,
    ST_FDIV,
    ST_FDIV_WAIT,
    ST_RANGE,
    ST_CELL_WAIT,
    ST_WALL,
    ST_DONE
  } state_t;

endpackage

// ===== src/grw_ram.sv =====
// ----------------------------------------------------------------------------
// grw_ram
// single port synchronous ram, registered read
// ----------------------------------------------------------------------------
module grw_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== src/grw_div.sv =====
// ----------------------------------------------------------------------------
// grw_div
// unsigned restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module grw_div #(
  parameter int NUM_W = 46,
  parameter int DEN_W = 25
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quot,
  output logic             rem_nz
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] q_r, q_nxt;
  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [DEN_W-1:0] den_r, den_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             done_r, done_nxt;
  logic [DEN_W:0]   trial;
  logic             ge;

  always_comb begin
    trial    = {rem_r, q_r[NUM_W-1]};
    ge       = trial >= {1'b0, den_r};
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (start) begin
      q_nxt   = num;
      rem_nxt = '0;
      den_nxt = den;
      cnt_nxt = CNT_W'(NUM_W);
    end else if (cnt_r != '0) begin
      rem_nxt  = ge ? DEN_W'(trial - {1'b0, den_r}) : trial[DEN_W-1:0];
      q_nxt    = {q_r[NUM_W-2:0], ge};
      cnt_nxt  = cnt_r - CNT_W'(1);
      done_nxt = (cnt_r == CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign done   = done_r;
  assign quot   = q_r;
  assign rem_nz = |rem_r;

endmodule

// ===== src/grid_ray_wall_intersection_core.sv =====
// ----------------------------------------------------------------------------
// grid_ray_wall_intersection_core
// wall map in a row-wide ram, ray walk over grid lines with a shared divider
// ----------------------------------------------------------------------------
// operation: a cell write reads its row, then writes the merged row back; a ray is taken,
//   then per pass one division finds the start line, and each line crossed takes two
//   divisions on the shared one-bit-per-cycle divider, up to GRID lines per pass; ST_DONE
//   then loads the result once the output is free; NUM_W is 46 at the default parameters
// throughput: one item at a time; the next item is taken once the cell write or ray is done
// reset: synchronous active low; control and config registers go to their reset values
//   and all row valid bits clear, so the whole map reads as empty at once, no clearing pass
module grid_ray_wall_intersection_core #(
  parameter int GRID      = grw_pkg::GRID_DEF,  // power of two
  parameter int FRAC_BITS = grw_pkg::FRAC_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // configuration write channel
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [grw_pkg::CFG_W-1:0]   cfg_index,
  input  logic [grw_pkg::CRD_W-1:0]   cfg_data,
  // input items
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_kind,
  input  logic [5:0]                  in_cell_row,
  input  logic [5:0]                  in_cell_col,
  input  logic                        in_cell_is_wall,
  input  logic signed [grw_pkg::END_W-1:0] in_ray_end_x,
  input  logic signed [grw_pkg::END_W-1:0] in_ray_end_y,
  // results
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [grw_pkg::END_W-1:0] out_hit_x,
  output logic signed [grw_pkg::END_W-1:0] out_hit_y,
  output logic [grw_pkg::SIDE_W-1:0]  out_hit_side
);

  import grw_pkg::*;

  // derived widths
  localparam int LOG2   = $clog2(GRID);
  localparam int J_W    = LOG2 + 1;
  localparam int SPAN_W = WIN_W + FRAC_BITS;
  localparam int DIFF_W = ((SPAN_W > CRD_W) ? SPAN_W : CRD_W) + 1;
  localparam int DLT_W  = END_W + 1;
  localparam int PROD_W = DIFF_W + DLT_W;
  localparam int NUM_W  = PROD_W;
  localparam int DEN_W  = (SPAN_W > DLT_W) ? SPAN_W : DLT_W;
  localparam int OTH_W  = PROD_W + 2;
  localparam int JS_W   = J_W + SPAN_W;
  localparam int CX_W   = ((SPAN_W + 1) > END_W) ? (SPAN_W + 1) : END_W;
  localparam int CMP_A  = (JS_W > (CX_W + LOG2)) ? JS_W : (CX_W + LOG2);
  localparam int CMP_W  = ((CMP_A > OTH_W) ? CMP_A : OTH_W) + 1;

  localparam logic signed [CMP_W-1:0] SAT_MAX = CMP_W'((64'sd1 <<< (END_W - 1)) - 1);
  localparam logic signed [CMP_W-1:0] SAT_MIN = -CMP_W'(64'sd1 <<< (END_W - 1));

  // configuration registers
  logic [WIN_W-1:0] window_size_r;
  logic [CRD_W-1:0] origin_x_r, origin_y_r, player_x_r, player_y_r;

  // control
  state_t state_r, state_nxt;
  logic   pass_r, pass_nxt;     // 0 vertical lines, 1 horizontal lines
  logic   back_r, back_nxt;     // walk toward lower line numbers
  logic   out_valid_r, out_valid_nxt;
  logic [GRID-1:0] row_vld_r, row_vld_nxt;

  // datapath registers
  logic [LOG2-1:0]          row_r, row_nxt;
  logic [LOG2-1:0]          col_r, col_nxt;
  logic                     wall_r, wall_nxt;
  logic [LOG2-1:0]          sel_r, sel_nxt;
  logic signed [CX_W-1:0]   cx_r, cx_nxt, cy_r, cy_nxt;
  logic signed [DLT_W-1:0]  dx_r, dx_nxt, dy_r, dy_nxt;
  logic [SIDE_W-1:0]        side_r, side_nxt;
  logic [J_W-1:0]           j_r, j_nxt;
  logic [JS_W-1:0]          jspan_r, jspan_nxt;
  logic [SPAN_W-1:0]        pos_r, pos_nxt;
  logic signed [DIFF_W-1:0] diff_r, diff_nxt;
  logic signed [PROD_W-1:0] prod_r, prod_nxt;
  logic                     neg_r, neg_nxt;
  logic signed [OTH_W-1:0]  other_r, other_nxt;
  logic signed [END_W-1:0]  hx_r, hx_nxt, hy_r, hy_nxt;
  logic [SIDE_W-1:0]        hs_r, hs_nxt;

  // map ram
  logic            ram_we;
  logic [LOG2-1:0] ram_addr;
  logic [GRID-1:0] ram_wdata, ram_rdata;

  // shared divider
  logic             div_start, div_done, div_rem_nz;
  logic [NUM_W-1:0] div_num, div_quot;
  logic [DEN_W-1:0] div_den;

  // helpers
  logic [SPAN_W-1:0]        span;
  logic signed [CRD_W:0]    o_main, o_oth;
  logic signed [DLT_W-1:0]  d_main, d_oth, dx_in, dy_in;
  logic [CRD_W-1:0]         player;
  logic signed [CMP_W-1:0]  cur_c, omain_c, js_c, lim_c, span_c, cyl_c, hxs_c, hys_c;
  logic signed [OTH_W-1:0]  q_s;
  logic [LOG2-1:0]          line, cell_idx;
  logic                     lim_ok, end_pass, wall_bit;
  logic [GRID-1:0]          merged;

  grw_ram #(
    .WIDTH (GRID),
    .DEPTH (GRID)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  grw_div #(
    .NUM_W (NUM_W),
    .DEN_W (DEN_W)
  ) u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (div_start),
    .num    (div_num),
    .den    (div_den),
    .done   (div_done),
    .quot   (div_quot),
    .rem_nz (div_rem_nz)
  );

  // config writes are always taken
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_size_r <= WIN_RESET;
      origin_x_r    <= '0;
      origin_y_r    <= '0;
      player_x_r    <= '0;
      player_y_r    <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_WINDOW_SIZE: window_size_r <= cfg_data[WIN_W-1:0];
        CFG_ORIGIN_X:    origin_x_r    <= cfg_data;
        CFG_ORIGIN_Y:    origin_y_r    <= cfg_data;
        CFG_PLAYER_X:    player_x_r    <= cfg_data;
        CFG_PLAYER_Y:    player_y_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  // pass-dependent operand selection: the vertical pass walks x, the horizontal y
  always_comb begin
    span   = {window_size_r, FRAC_BITS'(0)};
    o_main = pass_r ? $signed({1'b0, origin_y_r}) : $signed({1'b0, origin_x_r});
    o_oth  = pass_r ? $signed({1'b0, origin_x_r}) : $signed({1'b0, origin_y_r});
    d_main = pass_r ? dy_r : dx_r;
    d_oth  = pass_r ? dx_r : dy_r;
    player = pass_r ? player_y_r : player_x_r;
    dx_in  = DLT_W'(in_ray_end_x) - DLT_W'($signed({1'b0, origin_x_r}));
    dy_in  = DLT_W'(in_ray_end_y) - DLT_W'($signed({1'b0, origin_y_r}));

    cur_c   = pass_r ? CMP_W'(cy_r) : CMP_W'(cx_r);
    omain_c = CMP_W'(o_main);
    js_c    = $signed(CMP_W'(jspan_r));
    lim_c   = CMP_W'(cy_r) <<< LOG2;
    cyl_c   = CMP_W'(cy_r);
    span_c  = $signed(CMP_W'(span));

    // horizontal pass stays short of the vertical hit
    if (back_r) begin
      lim_ok = (cyl_c < 0) || (js_c > lim_c);
    end else begin
      lim_ok = (cyl_c > span_c) || (js_c < lim_c);
    end

    // floor division from the unsigned quotient
    q_s = neg_r ? (-$signed(OTH_W'(div_quot)) - $signed(OTH_W'(div_rem_nz)))
                : $signed(OTH_W'(div_quot));

    line     = back_r ? LOG2'(j_r - J_W'(1)) : LOG2'(j_r);
    cell_idx = div_quot[LOG2-1:0];
    wall_bit = row_vld_r[row_r] && ram_rdata[sel_r];

    merged         = row_vld_r[row_r] ? ram_rdata : '0;
    merged[col_r]  = wall_r;

    // output saturation
    hxs_c = CMP_W'(cx_r);
    hys_c = CMP_W'(cy_r);
  end

  // next state and datapath
  always_comb begin
    state_nxt     = state_r;
    pass_nxt      = pass_r;
    back_nxt      = back_r;
    out_valid_nxt = out_valid_r && !out_ready;
    row_vld_nxt   = row_vld_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    wall_nxt      = wall_r;
    sel_nxt       = sel_r;
    cx_nxt        = cx_r;
    cy_nxt        = cy_r;
    dx_nxt        = dx_r;
    dy_nxt        = dy_r;
    side_nxt      = side_r;
    j_nxt         = j_r;
    jspan_nxt     = jspan_r;
    pos_nxt       = pos_r;
    diff_nxt      = diff_r;
    prod_nxt      = prod_r;
    neg_nxt       = neg_r;
    other_nxt     = other_r;
    hx_nxt        = hx_r;
    hy_nxt        = hy_r;
    hs_nxt        = hs_r;
    ram_we        = 1'b0;
    ram_addr      = row_r;
    ram_wdata     = merged;
    div_start     = 1'b0;
    div_num       = NUM_W'(player) << LOG2;
    div_den       = DEN_W'(span);
    in_ready      = (state_r == ST_IDLE);
    end_pass      = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (!in_kind) begin
            // cell write: read the row now, merge next cycle
            if ((32'(in_cell_row) < GRID) && (32'(in_cell_col) < GRID)) begin
              row_nxt   = LOG2'(in_cell_row);
              col_nxt   = LOG2'(in_cell_col);
              wall_nxt  = in_cell_is_wall;
              ram_addr  = LOG2'(in_cell_row);
              state_nxt = ST_MAP_WB;
            end
          end else begin
            cx_nxt   = CX_W'(in_ray_end_x);
            cy_nxt   = CX_W'(in_ray_end_y);
            dx_nxt   = dx_in;
            dy_nxt   = dy_in;
            side_nxt = SIDE_NONE;
            pass_nxt = 1'b0;
            if (window_size_r == '0) begin
              state_nxt = ST_DONE;
            end else if (dx_in != '0) begin
              state_nxt = ST_PASS;
            end else if (dy_in != '0) begin
              pass_nxt  = 1'b1;
              state_nxt = ST_PASS;
            end else begin
              state_nxt = ST_DONE;
            end
          end
        end
      end

      ST_MAP_WB: begin
        ram_we              = 1'b1;
        row_vld_nxt[row_r]  = 1'b1;
        state_nxt           = ST_IDLE;
      end

      ST_PASS: begin
        // starting line = player * GRID / span
        div_start = 1'b1;
        back_nxt  = omain_c > cur_c;
        state_nxt = ST_START;
      end

      ST_START: begin
        if (div_done) begin
          if (back_r) begin
            j_nxt     = (div_quot >= NUM_W'(GRID)) ? J_W'(GRID) : J_W'(div_quot);
            state_nxt = ST_STEP;
          end else if (div_quot >= NUM_W'(GRID - 1)) begin
            end_pass = 1'b1;
          end else begin
            j_nxt     = J_W'(div_quot) + J_W'(1);
            state_nxt = ST_STEP;
          end
        end
      end

      ST_STEP: begin
        if (back_r ? (j_r == '0) : (32'(j_r) >= GRID)) begin
          end_pass = 1'b1;
        end else begin
          jspan_nxt = JS_W'(j_r) * JS_W'(span);
          state_nxt = ST_LIMIT;
        end
      end

      ST_LIMIT: begin
        if (pass_r && !lim_ok) begin
          end_pass = 1'b1;
        end else begin
          pos_nxt   = SPAN_W'(jspan_r >> LOG2);
          diff_nxt  = DIFF_W'($signed({1'b0, SPAN_W'(jspan_r >> LOG2)})) - DIFF_W'(o_main);
          state_nxt = ST_MUL;
        end
      end

      ST_MUL: begin
        prod_nxt  = diff_r * d_oth;
        state_nxt = ST_FDIV;
      end

      ST_FDIV: begin
        div_start = 1'b1;
        div_num   = prod_r[PROD_W-1] ? NUM_W'(-prod_r) : NUM_W'(prod_r);
        div_den   = d_main[DLT_W-1] ? DEN_W'(DLT_W'(-d_main)) : DEN_W'(DLT_W'(d_main));
        neg_nxt   = prod_r[PROD_W-1] ^ d_main[DLT_W-1];
        state_nxt = ST_FDIV_WAIT;
      end

      ST_FDIV_WAIT: begin
        if (div_done) begin
          other_nxt = OTH_W'(o_oth) + q_s;
          state_nxt = ST_RANGE;
        end
      end

      ST_RANGE: begin
        // crossing must lie strictly inside the map
        if (!((other_r > 0) && (CMP_W'(other_r) < span_c))) begin
          end_pass = 1'b1;
        end else begin
          div_start = 1'b1;
          div_num   = NUM_W'(other_r[SPAN_W-1:0]) << LOG2;
          state_nxt = ST_CELL_WAIT;
        end
      end

      ST_CELL_WAIT: begin
        if (div_done) begin
          ram_addr  = pass_r ? line : cell_idx;
          row_nxt   = pass_r ? line : cell_idx;
          sel_nxt   = pass_r ? cell_idx : line;
          state_nxt = ST_WALL;
        end
      end

      ST_WALL: begin
        if (wall_bit) begin
          if (pass_r) begin
            cx_nxt   = CX_W'(other_r);
            cy_nxt   = $signed(CX_W'(pos_r));
            side_nxt = SIDE_HORZ;
          end else begin
            cx_nxt   = $signed(CX_W'(pos_r));
            cy_nxt   = CX_W'(other_r);
            side_nxt = SIDE_VERT;
          end
          end_pass = 1'b1;
        end else begin
          j_nxt     = back_r ? (j_r - J_W'(1)) : (j_r + J_W'(1));
          state_nxt = ST_STEP;
        end
      end

      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          hx_nxt        = (hxs_c > SAT_MAX) ? END_W'(SAT_MAX) :
                          (hxs_c < SAT_MIN) ? END_W'(SAT_MIN) : END_W'(cx_r);
          hy_nxt        = (hys_c > SAT_MAX) ? END_W'(SAT_MAX) :
                          (hys_c < SAT_MIN) ? END_W'(SAT_MIN) : END_W'(cy_r);
          hs_nxt        = side_r;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase

    // a pass ends: go on to the horizontal pass or finish
    if (end_pass) begin
      if (!pass_r && (dy_r != '0)) begin
        pass_nxt  = 1'b1;
        state_nxt = ST_PASS;
      end else begin
        state_nxt = ST_DONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pass_r      <= 1'b0;
      back_r      <= 1'b0;
      out_valid_r <= 1'b0;
      row_vld_r   <= '0;
    end else begin
      state_r     <= state_nxt;
      pass_r      <= pass_nxt;
      back_r      <= back_nxt;
      out_valid_r <= out_valid_nxt;
      row_vld_r   <= row_vld_nxt;
    end
    row_r   <= row_nxt;
    col_r   <= col_nxt;
    wall_r  <= wall_nxt;
    sel_r   <= sel_nxt;
    cx_r    <= cx_nxt;
    cy_r    <= cy_nxt;
    dx_r    <= dx_nxt;
    dy_r    <= dy_nxt;
    side_r  <= side_nxt;
    j_r     <= j_nxt;
    jspan_r <= jspan_nxt;
    pos_r   <= pos_nxt;
    diff_r  <= diff_nxt;
    prod_r  <= prod_nxt;
    neg_r   <= neg_nxt;
    other_r <= other_nxt;
    hx_r    <= hx_nxt;
    hy_r    <= hy_nxt;
    hs_r    <= hs_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_hit_x    = hx_r;
  assign out_hit_y    = hy_r;
  assign out_hit_side = hs_r;

endmodule

// ===== tb/sv/grw_ray_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grw_ray_checker
// watches the config, item and result channels of the ray core, keeps its own
// wall map and registers, predicts every ray hit and compares each result
// ----------------------------------------------------------------------------
module grw_ray_checker (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_valid,
  input  logic                              cfg_ready,
  input  grw_pkg::cfg_idx_t                 cfg_index,
  input  logic [grw_pkg::CRD_W-1:0]         cfg_data,
  input  logic                              in_valid,
  input  logic                              in_ready,
  input  logic                              in_kind,
  input  logic [5:0]                        in_cell_row,
  input  logic [5:0]                        in_cell_col,
  input  logic                              in_cell_is_wall,
  input  logic signed [grw_pkg::END_W-1:0]  in_ray_end_x,
  input  logic signed [grw_pkg::END_W-1:0]  in_ray_end_y,
  input  logic                              out_valid,
  input  logic                              out_ready,
  input  logic signed [grw_pkg::END_W-1:0]  out_hit_x,
  input  logic signed [grw_pkg::END_W-1:0]  out_hit_y,
  input  logic [grw_pkg::SIDE_W-1:0]        out_hit_side,
  output int                                errors,
  output int                                pending
);
  import grw_pkg::*;

  localparam longint GRID = GRID_DEF;
  localparam longint FRAC = FRAC_DEF;

  typedef struct packed {
    logic signed [END_W-1:0] x;
    logic signed [END_W-1:0] y;
    side_t                   side;
  } hit_t;

  bit     wall_q [0:GRID*GRID-1];
  longint win_sz, org_x, org_y, ply_x, ply_y;
  hit_t   hits_due [$];

  function automatic longint floor_div(longint n, longint d);
    longint q;
    q = n / d;
    if ((n % d != 0) && ((n < 0) != (d < 0))) q--;
    return q;
  endfunction

  function automatic logic signed [END_W-1:0] clip24(longint v);
    if (v > 8388607) v = 8388607;
    if (v < -8388608) v = -8388608;
    return v[END_W-1:0];
  endfunction

  function automatic bit is_wall(longint row, longint col);
    if (row < 0 || col < 0 || row >= GRID || col >= GRID) return 0;
    return wall_q[row*GRID + col];
  endfunction

  function automatic hit_t trace_ray(longint ex, longint ey);
    longint cx, cy, dx, dy, span, j, pos, oth, first, lim;
    side_t  sd;
    hit_t   r;
    cx = ex; cy = ey; sd = SIDE_NONE;
    dx = ex - org_x; dy = ey - org_y;
    span = win_sz << FRAC;
    // vertical grid lines
    if (span > 0 && dx != 0) begin
      first = ply_x * GRID / span;
      if (org_x > ex) begin
        for (j = (first < GRID) ? first : GRID; j > 0; j--) begin
          pos = j * span / GRID;
          oth = org_y + floor_div((pos - org_x) * dy, dx);
          if (!(oth > 0 && oth < span)) break;
          if (is_wall(oth * GRID / span, j - 1)) begin
            cx = pos; cy = oth; sd = SIDE_VERT;
            break;
          end
        end
      end else begin
        for (j = first + 1; j < GRID; j++) begin
          pos = j * span / GRID;
          oth = org_y + floor_div((pos - org_x) * dy, dx);
          if (!(oth > 0 && oth < span)) break;
          if (is_wall(oth * GRID / span, j)) begin
            cx = pos; cy = oth; sd = SIDE_VERT;
            break;
          end
        end
      end
    end
    // horizontal grid lines, bounded by the vertical result
    if (span > 0 && dy != 0) begin
      first = ply_y * GRID / span;
      lim = cy;
      if (org_y > cy) begin
        for (j = (first < GRID) ? first : GRID;
             j > 0 && (lim < 0 || j * span > lim * GRID); j--) begin
          pos = j * span / GRID;
          oth = org_x + floor_div((pos - org_y) * dx, dy);
          if (!(oth > 0 && oth < span)) break;
          if (is_wall(j - 1, oth * GRID / span)) begin
            cx = oth; cy = pos; sd = SIDE_HORZ;
            break;
          end
        end
      end else begin
        for (j = first + 1;
             j < GRID && (lim > span || j * span < lim * GRID); j++) begin
          pos = j * span / GRID;
          oth = org_x + floor_div((pos - org_y) * dx, dy);
          if (!(oth > 0 && oth < span)) break;
          if (is_wall(j, oth * GRID / span)) begin
            cx = oth; cy = pos; sd = SIDE_HORZ;
            break;
          end
        end
      end
    end
    r.x = clip24(cx);
    r.y = clip24(cy);
    r.side = sd;
    return r;
  endfunction

  always @(posedge clk) begin
    hit_t exp_hit;
    if (!rst_n) begin
      foreach (wall_q[i]) wall_q[i] = 0;
      win_sz = WIN_RESET;
      org_x = 0; org_y = 0; ply_x = 0; ply_y = 0;
      hits_due.delete();
      errors = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_WINDOW_SIZE: win_sz = cfg_data[WIN_W-1:0];
          CFG_ORIGIN_X:    org_x = cfg_data;
          CFG_ORIGIN_Y:    org_y = cfg_data;
          CFG_PLAYER_X:    ply_x = cfg_data;
          CFG_PLAYER_Y:    ply_y = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        if (in_kind)
          hits_due.insert(hits_due.size(),
                          trace_ray(longint'(in_ray_end_x), longint'(in_ray_end_y)));
        else
          wall_q[in_cell_row*GRID + in_cell_col] = in_cell_is_wall;
      end
      if (out_valid && out_ready) begin
        if (hits_due.size() == 0) begin
          $error("unexpected result x=%0d y=%0d side=%0d", out_hit_x, out_hit_y,
                 out_hit_side);
          errors++;
        end else begin
          exp_hit = hits_due.pop_front();
          if (out_hit_x !== exp_hit.x) begin
            $error("hit_x expected %0d actual %0d", exp_hit.x, out_hit_x);
            errors++;
          end
          if (out_hit_y !== exp_hit.y) begin
            $error("hit_y expected %0d actual %0d", exp_hit.y, out_hit_y);
            errors++;
          end
          if (out_hit_side !== exp_hit.side) begin
            $error("hit_side expected %0d actual %0d", exp_hit.side, out_hit_side);
            errors++;
          end
        end
      end
    end
    pending = hits_due.size();
  end

endmodule

// ===== tb/sv/tb_grid_ray_wall_intersection_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_grid_ray_wall_intersection_core
// drives cell writes, rays and register settings into the ray core with random
// idling on both sides; a checker beside the core predicts and compares results
// ----------------------------------------------------------------------------
module tb_grid_ray_wall_intersection_core;
  import grw_pkg::*;

  localparam logic KIND_CELL = 1'b0;
  localparam logic KIND_RAY  = 1'b1;
  localparam int   STALL_LIMIT = 100000;  // cycles with no transfer at all
  localparam int   SETTLE = 40;           // covers a trailing cell write
  localparam int   PHASES = 6;
  localparam int   PHASE_ITEMS = 280;

  logic clk, rst_n;
  logic cfg_valid, cfg_ready;
  cfg_idx_t cfg_index;
  logic [CRD_W-1:0] cfg_data;
  logic in_valid, in_ready, in_kind, in_cell_is_wall;
  logic [5:0] in_cell_row, in_cell_col;
  logic signed [END_W-1:0] in_ray_end_x, in_ray_end_y;
  logic out_valid, out_ready;
  logic signed [END_W-1:0] out_hit_x, out_hit_y;
  logic [SIDE_W-1:0] out_hit_side;
  int errors, pending;
  int idle_cycles;
  bit no_idle;      // long stretch without any idling
  int span_now;     // current span in fixed point, for shaping endpoints

  grid_ray_wall_intersection_core u_dut (.*);

  grw_ray_checker u_chk (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // result side back-pressure
  initial out_ready = 0;
  always @(negedge clk) out_ready <= no_idle || ($urandom_range(99) >= 14);

  // watchdog: nothing moved on any channel for too long
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // drop valid once the last item is taken, wait for all rays back, then for a
  // trailing cell write to settle
  task automatic drain();
    @(negedge clk);
    in_valid = 0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, int unsigned val);
    @(negedge clk);
    cfg_index = idx;
    cfg_data  = CRD_W'(val);
    cfg_valid = 1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 0;
    if (idx == CFG_WINDOW_SIZE) span_now = (val & 12'hFFF) << FRAC_DEF;
  endtask

  // one item transfer; valid stays up across back-to-back items
  task automatic send(logic kind, int row, int col, logic wall, int ex, int ey);
    @(negedge clk);
    while (!no_idle && $urandom_range(99) < 14) begin
      in_valid = 0;
      @(negedge clk);
    end
    in_kind = kind;
    in_cell_row = 6'(row);
    in_cell_col = 6'(col);
    in_cell_is_wall = wall;
    in_ray_end_x = END_W'(ex);
    in_ray_end_y = END_W'(ey);
    in_valid = 1;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic put_cell(int row, int col, logic wall);
    send(KIND_CELL, row, col, wall, $urandom, $urandom);
  endtask

  task automatic ray(int ex, int ey);
    send(KIND_RAY, $urandom, $urandom, 1'($urandom), ex, ey);
  endtask

  function automatic int pick_end();
    int r;
    r = $urandom_range(9);
    if (r == 0) return $urandom;                         // anywhere, all bits
    if (r == 1) return -int'($urandom_range(span_now + 1));
    return $urandom_range(span_now + span_now / 4 + 1);  // mostly on the map
  endfunction

  function automatic int pick_coord(int p);
    if (p == 0) return 0;
    if (p == 1) return 20'hFFFFF;
    if ($urandom_range(3) == 0) return $urandom;
    return $urandom_range(span_now > 0 ? span_now - 1 : 0);
  endfunction

  initial begin
    int win;
    rst_n = 0;
    no_idle = 0;
    cfg_valid = 0; cfg_index = CFG_WINDOW_SIZE; cfg_data = 0;
    in_valid = 0; in_kind = KIND_CELL; in_cell_row = 0; in_cell_col = 0;
    in_cell_is_wall = 0; in_ray_end_x = 0; in_ray_end_y = 0;
    span_now = 512 << FRAC_DEF;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // directed: reset settings, origin in the middle of a 512 pixel map
    write_reg(CFG_WINDOW_SIZE, 512);
    write_reg(CFG_ORIGIN_X, 256 << 8);
    write_reg(CFG_ORIGIN_Y, 256 << 8);
    write_reg(CFG_PLAYER_X, 256 << 8);
    write_reg(CFG_PLAYER_Y, 256 << 8);
    put_cell(0, 0, 1);
    put_cell(63, 63, 1);
    put_cell(32, 40, 1);
    put_cell(40, 32, 1);
    put_cell(20, 20, 1);
    put_cell(20, 20, 0);       // cleared again
    ray(500 << 8, 256 << 8);   // toward the wall at row 32, col 40
    ray(256 << 8, 500 << 8);   // zero dx, horizontal pass only
    ray(10 << 8, 256 << 8);    // zero dy, backward vertical pass
    ray(8388607, 8388607);     // largest endpoint
    ray(-8388608, -8388608);   // smallest endpoint
    ray(256 << 8, 256 << 8);   // endpoint on the origin
    ray(1 << 8, 1 << 8);       // toward the corner wall
    ray(511 << 8, 511 << 8);
    drain();
    write_reg(CFG_PLAYER_X, 20'hFFFFF);   // player beyond the map
    write_reg(CFG_PLAYER_Y, 20'hFFFFF);
    ray(5 << 8, 300 << 8);
    ray(500 << 8, 100 << 8);
    drain();
    write_reg(CFG_WINDOW_SIZE, 0);        // no map, endpoint comes back
    ray(1234, -5678);
    drain();

    // random phases, each with its own settings; every drain pauses the sender
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: win = 1;
        1: win = 4095;
        2: win = 512;
        default: win = $urandom_range(4095, 1);
      endcase
      write_reg(CFG_WINDOW_SIZE, win);
      write_reg(CFG_ORIGIN_X, pick_coord(p));
      write_reg(CFG_ORIGIN_Y, pick_coord(p + 2));
      write_reg(CFG_PLAYER_X, pick_coord(p + 4));
      write_reg(CFG_PLAYER_Y, pick_coord(p + 1));
      no_idle = (p == 3);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        // dense walls keep most rays short
        if ($urandom_range(99) < 62)
          put_cell($urandom_range(63), $urandom_range(63), $urandom_range(99) < 70);
        else
          ray(pick_end(), pick_end());
      end
      no_idle = 0;
      drain();
    end

    @(negedge clk);
    in_valid = 0;
    drain();
    if (errors == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
